// ===== rtl/quaternion_to_euler_angles_macros.svh =====
// Assertion macros for the quaternion to Euler angle converter.
// Included by the modules that carry concurrent checks; no other dependency.
`ifndef QUATERNION_TO_EULER_ANGLES_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_MACROS_SVH

// same-cycle implication
`define QTE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define QTE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/qte_pkg.sv =====
// Types, constants and arithmetic helpers for the quaternion to Euler converter.
// No dependencies.
`timescale 1ns / 1ps

package qte_pkg;

    localparam int SW  = 34;   // width of the Q.28 sums
    localparam int CW  = 38;   // CORDIC x/y datapath width
    localparam int QW  = 58;   // square root datapath width
    localparam int MW  = 28;   // magnitude of the pitch sine
    localparam int SQRT_STEPS = 29;

    localparam int CH_ROLL  = 0;
    localparam int CH_PITCH = 1;
    localparam int CH_YAW   = 2;

    typedef logic signed [SW-1:0] sum_t;
    typedef logic signed [CW-1:0] cval_t;

    localparam sum_t ONE_Q28 = 34'sd268435456;
    localparam logic [QW-1:0] RAD_ONE = 58'h100000000000000; // 2^56
    localparam logic signed [15:0] QUARTER_TURN = 16'sd16384;
    localparam logic [31:0] HALF_TURN = 32'h80000000;
    localparam logic [31:0] ROUND_HALF = 32'h00008000;

    typedef struct packed {
        cval_t       x;
        cval_t       y;
        logic [31:0] acc;
        logic        zero;
    } cordic_t;

    typedef struct packed {
        cordic_t [2:0] ch;
        logic          clamp;
        logic          psign;
    } cdst_t;

    typedef struct packed {
        logic [QW-1:0] n;
        logic [QW-1:0] r;
        sum_t          sr;
        sum_t          cr;
        sum_t          sy;
        sum_t          cy;
        sum_t          sp;
        logic          clamp;
    } sqrt_t;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic               clamped;
    } euler_t;

    // atan(2^-i), 2^32 per turn
    function automatic logic [31:0] atan_angle(input logic [4:0] i);
        logic [31:0] a;
        case (i)
            5'd0:  a = 32'd536870912;
            5'd1:  a = 32'd316933406;
            5'd2:  a = 32'd167458907;
            5'd3:  a = 32'd85004756;
            5'd4:  a = 32'd42667331;
            5'd5:  a = 32'd21354465;
            5'd6:  a = 32'd10679838;
            5'd7:  a = 32'd5340245;
            5'd8:  a = 32'd2670163;
            5'd9:  a = 32'd1335087;
            5'd10: a = 32'd667544;
            5'd11: a = 32'd333772;
            5'd12: a = 32'd166886;
            5'd13: a = 32'd83443;
            5'd14: a = 32'd41722;
            5'd15: a = 32'd20861;
            5'd16: a = 32'd10430;
            5'd17: a = 32'd5215;
            5'd18: a = 32'd2608;
            5'd19: a = 32'd1304;
            5'd20: a = 32'd652;
            5'd21: a = 32'd326;
            5'd22: a = 32'd163;
            5'd23: a = 32'd81;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

    // fold into the right half plane before vectoring
    function automatic cordic_t cordic_init(input sum_t y, input sum_t x);
        cordic_t c;
        c.zero = (x == '0) && (y == '0);
        if (x < 0)
        begin
            c.x   = -cval_t'(x);
            c.y   = -cval_t'(y);
            c.acc = HALF_TURN;
        end
        else
        begin
            c.x   = cval_t'(x);
            c.y   = cval_t'(y);
            c.acc = '0;
        end
        return c;
    endfunction

    function automatic cordic_t cordic_step(input cordic_t c, input int unsigned i);
        cordic_t o;
        cval_t   dx;
        cval_t   dy;
        dx = c.y >>> i;
        dy = c.x >>> i;
        o  = c;
        if (c.y > 0)
        begin
            o.x   = c.x + dx;
            o.y   = c.y - dy;
            o.acc = c.acc + atan_angle(5'(i));
        end
        else
        begin
            o.x   = c.x - dx;
            o.y   = c.y + dy;
            o.acc = c.acc - atan_angle(5'(i));
        end
        return o;
    endfunction

    function automatic sqrt_t sqrt_step(input sqrt_t s, input logic [QW-1:0] bitv);
        sqrt_t         o;
        logic [QW-1:0] t;
        o = s;
        t = s.r + bitv;
        if (s.n >= t)
        begin
            o.n = s.n - t;
            o.r = (s.r >> 1) + bitv;
        end
        else
        begin
            o.r = s.r >> 1;
        end
        return o;
    endfunction

    function automatic logic signed [15:0] cordic_round(input cordic_t c);
        logic [31:0] a;
        a = c.acc + ROUND_HALF;
        return c.zero ? 16'sd0 : $signed(a[31:16]);
    endfunction

endpackage

// ===== rtl/qte_if.sv =====
// Valid/ready channel interfaces for the quaternion input and the angle output.
// No dependencies.
`timescale 1ns / 1ps

interface qte_quat_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;

    modport source (output valid, output quat_w, output quat_x, output quat_y,
                    output quat_z, input ready);
    modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                    input quat_z, output ready);
endinterface

interface qte_euler_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic               pitch_clamped;

    modport source (output valid, output roll_angle, output pitch_angle,
                    output yaw_angle, output pitch_clamped, input ready);
    modport sink   (input valid, input roll_angle, input pitch_angle,
                    input yaw_angle, input pitch_clamped, output ready);
endinterface

// ===== rtl/quaternion_to_euler_angles.sv =====
// Quaternion (Q2.14) to ZYX roll/pitch/yaw binary angles, fully pipelined.
// Depends on qte_pkg, qte_if.sv and quaternion_to_euler_angles_macros.svh.
//
// Usage:
//   quat  (sink)  : one quaternion per transfer, valid/ready handshake.
//   euler (source): roll, pitch, yaw and the pitch clamp flag, one per transfer.
// Throughput: one quaternion per cycle while the output keeps draining.
// Pipeline from input transfer to euler.valid: product, sum and square
//   stages, 29 square root stages for the pitch cosine, one fold stage and
//   one stage per CORDIC iteration; roll and yaw ride alongside the square
//   root.
// The result lands in a two-entry output buffer. While that buffer is full
//   the whole pipeline holds and quat.ready is low; nothing is dropped.
// Reset clears all valid bits and the output buffer; no warm-up pass.
// Results follow input order exactly.
`timescale 1ns / 1ps
`include "quaternion_to_euler_angles_macros.svh"

module quaternion_to_euler_angles #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    qte_quat_if.sink    quat,
    qte_euler_if.source euler
);
    import qte_pkg::*;

    logic en;
    logic push;
    logic pop;

    // stage 1: products
    logic               s1_v_reg;
    logic signed [31:0] p_wx_reg, p_yz_reg, p_wz_reg, p_xy_reg, p_wy_reg, p_zx_reg;
    logic signed [31:0] p_xx_reg, p_yy_reg, p_zz_reg;

    // stage 2: sums
    logic            s2_v_reg;
    sum_t            sr_reg, cr_reg, sy_reg, cy_reg, sp_reg;
    logic            clamp_reg;
    logic [MW-1:0]   mag_reg;
    sum_t            sr_next, cr_next, sy_next, cy_next, sp_next;
    sum_t            spabs;

    // stage 3: square of the pitch sine
    logic              s3_v_reg;
    sum_t              sr3_reg, cr3_reg, sy3_reg, cy3_reg, sp3_reg;
    logic              clamp3_reg;
    logic [2*MW-1:0]   sq_reg;

    sqrt_t sq_in;
    sqrt_t sqs_reg   [SQRT_STEPS];
    logic  sqs_v_reg [SQRT_STEPS];

    cdst_t cd_reg   [CORDIC_STEPS+1];
    logic  cd_v_reg [CORDIC_STEPS+1];
    cdst_t cd_init;

    euler_t fin;
    euler_t ob0_reg, ob1_reg;
    logic [1:0] cnt_reg;

    assign en         = (cnt_reg != 2'd2);
    assign quat.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= quat.valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_wx_reg <= quat.quat_w * quat.quat_x;
            p_yz_reg <= quat.quat_y * quat.quat_z;
            p_wz_reg <= quat.quat_w * quat.quat_z;
            p_xy_reg <= quat.quat_x * quat.quat_y;
            p_wy_reg <= quat.quat_w * quat.quat_y;
            p_zx_reg <= quat.quat_z * quat.quat_x;
            p_xx_reg <= quat.quat_x * quat.quat_x;
            p_yy_reg <= quat.quat_y * quat.quat_y;
            p_zz_reg <= quat.quat_z * quat.quat_z;
        end
    end

    always_comb
    begin
        sr_next = (sum_t'(p_wx_reg) + sum_t'(p_yz_reg)) <<< 1;
        sy_next = (sum_t'(p_wz_reg) + sum_t'(p_xy_reg)) <<< 1;
        sp_next = (sum_t'(p_wy_reg) - sum_t'(p_zx_reg)) <<< 1;
        cr_next = ONE_Q28 - ((sum_t'(p_xx_reg) + sum_t'(p_yy_reg)) <<< 1);
        cy_next = ONE_Q28 - ((sum_t'(p_yy_reg) + sum_t'(p_zz_reg)) <<< 1);
        spabs   = sp_next[SW-1] ? -sp_next : sp_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sr_reg    <= sr_next;
            cr_reg    <= cr_next;
            sy_reg    <= sy_next;
            cy_reg    <= cy_next;
            sp_reg    <= sp_next;
            clamp_reg <= (sp_next >= ONE_Q28) || (sp_next <= -ONE_Q28);
            mag_reg   <= spabs[MW-1:0];

            sr3_reg    <= sr_reg;
            cr3_reg    <= cr_reg;
            sy3_reg    <= sy_reg;
            cy3_reg    <= cy_reg;
            sp3_reg    <= sp_reg;
            clamp3_reg <= clamp_reg;
            sq_reg     <= mag_reg * mag_reg;
        end
    end

    always_comb
    begin
        sq_in.n     = RAD_ONE - QW'(sq_reg);
        sq_in.r     = '0;
        sq_in.sr    = sr3_reg;
        sq_in.cr    = cr3_reg;
        sq_in.sy    = sy3_reg;
        sq_in.cy    = cy3_reg;
        sq_in.sp    = sp3_reg;
        sq_in.clamp = clamp3_reg;
    end

    // one root digit per stage, 4^28 down to 4^0
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        localparam logic [QW-1:0] BITV = QW'(1) << (2 * (SQRT_STEPS - 1 - k));
        sqrt_t src;
        logic  src_v;
        if (k == 0)
        begin : g_first
            assign src   = sq_in;
            assign src_v = s3_v_reg;
        end
        else
        begin : g_rest
            assign src   = sqs_reg[k-1];
            assign src_v = sqs_v_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sqs_v_reg[k] <= 1'b0;
            else if (en)
                sqs_v_reg[k] <= src_v;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                sqs_reg[k] <= sqrt_step(src, BITV);
        end
    end

    always_comb
    begin
        cd_init.ch[CH_ROLL]  = cordic_init(sqs_reg[SQRT_STEPS-1].sr, sqs_reg[SQRT_STEPS-1].cr);
        cd_init.ch[CH_YAW]   = cordic_init(sqs_reg[SQRT_STEPS-1].sy, sqs_reg[SQRT_STEPS-1].cy);
        cd_init.ch[CH_PITCH] = cordic_init(sqs_reg[SQRT_STEPS-1].sp,
                                           $signed(sqs_reg[SQRT_STEPS-1].r[SW-1:0]));
        cd_init.clamp        = sqs_reg[SQRT_STEPS-1].clamp;
        cd_init.psign        = sqs_reg[SQRT_STEPS-1].sp[SW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cd_v_reg[0] <= 1'b0;
        else if (en)
            cd_v_reg[0] <= sqs_v_reg[SQRT_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            cd_reg[0] <= cd_init;
    end

    for (genvar j = 1; j <= CORDIC_STEPS; j++)
    begin : g_cordic
        cdst_t nxt;
        always_comb
        begin
            nxt = cd_reg[j-1];
            for (int c = 0; c < 3; c++)
                nxt.ch[c] = cordic_step(cd_reg[j-1].ch[c], j - 1);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cd_v_reg[j] <= 1'b0;
            else if (en)
                cd_v_reg[j] <= cd_v_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                cd_reg[j] <= nxt;
        end
    end

    always_comb
    begin
        logic signed [15:0] pr;
        pr          = cordic_round(cd_reg[CORDIC_STEPS].ch[CH_PITCH]);
        fin.roll    = cordic_round(cd_reg[CORDIC_STEPS].ch[CH_ROLL]);
        fin.yaw     = cordic_round(cd_reg[CORDIC_STEPS].ch[CH_YAW]);
        fin.clamped = cd_reg[CORDIC_STEPS].clamp;
        if (cd_reg[CORDIC_STEPS].clamp)
            fin.pitch = cd_reg[CORDIC_STEPS].psign ? -QUARTER_TURN : QUARTER_TURN;
        else if (pr > QUARTER_TURN)
            fin.pitch = QUARTER_TURN;
        else if (pr < -QUARTER_TURN)
            fin.pitch = -QUARTER_TURN;
        else
            fin.pitch = pr;
    end

    // two-entry output buffer
    assign push = en && cd_v_reg[CORDIC_STEPS];
    assign pop  = (cnt_reg != 2'd0) && euler.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (cnt_reg == 2'd2 && pop)
            ob0_reg <= ob1_reg;
        else if (push && (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop)))
            ob0_reg <= fin;
        if (push && cnt_reg == 2'd1 && !pop)
            ob1_reg <= fin;
    end

    assign euler.valid         = (cnt_reg != 2'd0);
    assign euler.roll_angle    = ob0_reg.roll;
    assign euler.pitch_angle   = ob0_reg.pitch;
    assign euler.yaw_angle     = ob0_reg.yaw;
    assign euler.pitch_clamped = ob0_reg.clamped;

    `QTE_ASSERT_NXT(a_accept_enters, clk, rst_n, quat.valid && quat.ready, s1_v_reg, "accepted quaternion did not enter pipeline")
    `QTE_ASSERT_NXT(a_full_holds, clk, rst_n, (cnt_reg == 2'd2) && !euler.ready, (cnt_reg == 2'd2) && $stable(ob0_reg), "stalled output buffer changed")
    `QTE_ASSERT_IMP(a_clamp_value, clk, rst_n, euler.valid && euler.pitch_clamped, (euler.pitch_angle == QUARTER_TURN) || (euler.pitch_angle == -QUARTER_TURN), "clamped pitch not a quarter turn")
    `QTE_ASSERT_IMP(a_pitch_range, clk, rst_n, euler.valid, (euler.pitch_angle <= QUARTER_TURN) && (euler.pitch_angle >= -QUARTER_TURN), "pitch beyond a quarter turn")

endmodule
